// ===== rtl/core/encoder_speed_controller_defines.svh =====
// Assertion macros for the encoder speed controller.
// Needs nothing else; included by the top level only.
`ifndef ENCODER_SPEED_CONTROLLER_DEFINES_SVH
`define ENCODER_SPEED_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define ESC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ESC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ESC_ASSERT(lbl, clk, rst_n, prop, msg)
`define ESC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/core/esc_pkg.sv =====
// Shared types, codes and arithmetic helpers of the encoder speed controller.
// No dependencies.
package esc_pkg;

  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgGain  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAlpha = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSlew  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMode  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgFlim  = 3'd4;

  localparam logic [1:0] ReqEdgeA = 2'd0;
  localparam logic [1:0] ReqEdgeB = 2'd1;
  localparam logic [1:0] ReqTick  = 2'd2;

  // serial units
  localparam int unsigned MulW     = 64;
  localparam int unsigned MulBW    = 16;
  localparam int unsigned MulCntW  = $clog2(MulBW + 1);
  localparam int unsigned DivNW    = 26;
  localparam int unsigned DivDW    = 16;
  localparam int unsigned DivCntW  = $clog2(DivNW + 1);

  localparam logic [DivNW-1:0] ClockHz   = 26'd32768;
  localparam logic [DivDW-1:0] SampleMax = 16'd1023;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_st_t;

  // signed divide by 2^k, truncating toward zero
  function automatic logic signed [MulW-1:0] div_pow2(input logic signed [MulW-1:0] v,
                                                      input logic [5:0] k);
    logic signed [MulW-1:0] bias;
    bias = v[MulW-1] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (v + bias) >>> k;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [MulW-1:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== rtl/core/encoder_speed_controller.sv =====
// Channel  | dir | data fields (low bit up)                               | tuser
// s_axis   | in  | capture_time[15:0], pot_value[25:16], zero pad         | req_type
// m_axis   | out | duty, speed_avg, filtered_error, setpoint, zero pad    | -
// cfg      | in  | cfg_idx_i selects register, cfg_data_i written on cfg_we_i
// One request at a time. An edge that updates a speed runs the serial divide, then the
// serial multiply; a tick runs the filter, gain and output multiplies, after a scaling
// multiply and divide in scaling mode. Reset sets all but operand and payload registers;
// the result register lets the next request in while it waits.
// Top level; depends on esc_pkg, esc_mul, esc_div and the defines header.
`include "encoder_speed_controller_defines.svh"
module encoder_speed_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [esc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [esc_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,  // capture_time, pot_value
  input  logic [1:0]                   s_axis_tuser,  // req_type
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [55:0]                  m_axis_tdata   // duty, speed_avg, filtered_error, setpoint
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EDIV  = 4'd1;
  localparam logic [3:0] S_EMUL  = 4'd2;
  localparam logic [3:0] S_MEAN  = 4'd3;
  localparam logic [3:0] S_TSCL  = 4'd4;
  localparam logic [3:0] S_TDIV  = 4'd5;
  localparam logic [3:0] S_TERR  = 4'd6;
  localparam logic [3:0] S_TFLT  = 4'd7;
  localparam logic [3:0] S_TGAIN = 4'd8;
  localparam logic [3:0] S_TOUT  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]  state_q;
  logic [15:0] gain_q, flim_q;
  logic [8:0]  alpha_q, slew_q;
  logic        mode_q;

  logic [15:0] last_a_q, last_b_q, speed_a_q, speed_b_q, mean_q;
  logic        phase_a_q, phase_b_q;
  logic signed [31:0] err_q, out_q;
  logic [9:0]  duty_q, setp_q;
  logic        req_b_q;
  logic [15:0] xd_q;
  logic        m_valid_q;
  logic [55:0] m_data_q;

  logic                            mul_go_q, div_go_q;
  logic                            mul_go_d, div_go_d;
  logic signed [esc_pkg::MulW-1:0] mul_a_q, mul_prod;
  logic [esc_pkg::MulBW-1:0]       mul_b_q;
  logic [esc_pkg::DivNW-1:0]       div_n_q, div_quo;
  logic [esc_pkg::DivDW-1:0]       div_d_q;
  esc_pkg::unit_st_t               mul_st, div_st;

  esc_mul u_mul (
    .clk_i, .rst_ni, .go_i(mul_go_q), .a_i(mul_a_q), .b_i(mul_b_q),
    .prod_o(mul_prod), .st_o(mul_st)
  );

  esc_div u_div (
    .clk_i, .rst_ni, .go_i(div_go_q), .dividend_i(div_n_q), .divisor_i(div_d_q),
    .quot_o(div_quo), .st_o(div_st)
  );

  logic        accept;
  logic [1:0]  in_req;
  logic [15:0] in_time, interval, cur_speed;
  logic [9:0]  in_pot;
  logic        sel_phase;
  logic signed [esc_pkg::MulW-1:0] freq_diff, spd_num, spd_div, err_e, flt_num, inner;
  logic signed [esc_pkg::MulW-1:0] out_num, p64;
  logic [15:0] spd_new;
  logic signed [31:0] new_err, new_out;
  logic [9:0]  new_duty;
  logic [15:0] fe16;

  always_comb begin
    accept    = s_axis_tvalid && s_axis_tready;
    in_req    = s_axis_tuser;
    in_time   = s_axis_tdata[15:0];
    in_pot    = s_axis_tdata[25:16];
    interval  = in_time - (in_req[0] ? last_b_q : last_a_q);
    sel_phase = in_req[0] ? phase_b_q : phase_a_q;
    cur_speed = req_b_q ? speed_b_q : speed_a_q;
    p64       = {{32{out_q[31]}}, out_q};

    freq_diff = $signed({48'd0, div_quo[15:0]}) - $signed({48'd0, cur_speed});
    spd_num   = $signed({40'd0, cur_speed, 8'd0}) + mul_prod;
    spd_div   = esc_pkg::div_pow2(spd_num, 6'd8);
    if (spd_div < 0) begin
      spd_new = '0;
    end else if (spd_div > 64'sd65535) begin
      spd_new = 16'hffff;
    end else begin
      spd_new = spd_div[15:0];
    end

    err_e   = $signed({48'd0, xd_q}) - $signed({48'd0, mean_q})
              - $signed({{32{err_q[31]}}, err_q});
    flt_num = mul_prod + ($signed({{32{err_q[31]}}, err_q}) <<< 8);
    new_err = esc_pkg::sat32(esc_pkg::div_pow2(flt_num, 6'd8));
    inner   = $signed({40'd0, xd_q, 8'd0}) + mul_prod - (p64 <<< 8);
    out_num = (p64 <<< 16) + mul_prod;
    new_out = esc_pkg::sat32(esc_pkg::div_pow2(out_num, 6'd16));
    if (new_out > 32'sd1023) begin
      new_duty = 10'd1023;
    end else if (new_out < 0) begin
      new_duty = '0;
    end else begin
      new_duty = new_out[9:0];
    end

    if (err_q > 32'sd32767) begin
      fe16 = 16'h7fff;
    end else if (err_q < -32'sd32768) begin
      fe16 = 16'h8000;
    end else begin
      fe16 = err_q[15:0];
    end

    // start pulses for the serial units
    mul_go_d = (state_q == S_IDLE && accept && in_req == esc_pkg::ReqTick && mode_q)
               || (state_q == S_EDIV && div_st.done)
               || (state_q == S_TERR)
               || ((state_q == S_TFLT || state_q == S_TGAIN) && mul_st.done);
    div_go_d = (state_q == S_IDLE && accept
                && (in_req == esc_pkg::ReqEdgeA || in_req == esc_pkg::ReqEdgeB)
                && sel_phase && interval != '0)
               || (state_q == S_TSCL && mul_st.done);
  end

  assign s_axis_tready = (state_q == S_IDLE);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= 16'd128;
      alpha_q <= 9'd179;
      slew_q  <= 9'd128;
      mode_q  <= 1'b0;
      flim_q  <= 16'd500;
    end else if (cfg_we_i) begin
      priority case (cfg_idx_i)
        esc_pkg::CfgGain:  gain_q  <= cfg_data_i;
        esc_pkg::CfgAlpha: alpha_q <= cfg_data_i[8:0];
        esc_pkg::CfgSlew:  slew_q  <= cfg_data_i[8:0];
        esc_pkg::CfgMode:  mode_q  <= cfg_data_i[0];
        esc_pkg::CfgFlim:  flim_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      last_a_q  <= '0;
      last_b_q  <= '0;
      phase_a_q <= 1'b0;
      phase_b_q <= 1'b0;
      speed_a_q <= '0;
      speed_b_q <= '0;
      mean_q    <= '0;
      err_q     <= '0;
      out_q     <= '0;
      duty_q    <= '0;
      setp_q    <= '0;
      m_valid_q <= 1'b0;
      mul_go_q  <= 1'b0;
      div_go_q  <= 1'b0;
    end else begin
      mul_go_q <= mul_go_d;
      div_go_q <= div_go_d;
      if (m_valid_q && m_axis_tready && state_q != S_DONE) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            priority case (in_req)
              esc_pkg::ReqEdgeA, esc_pkg::ReqEdgeB: begin
                if (in_req[0]) begin
                  last_b_q  <= in_time;
                  phase_b_q <= ~phase_b_q;
                end else begin
                  last_a_q  <= in_time;
                  phase_a_q <= ~phase_a_q;
                end
                if (sel_phase && interval != '0) begin
                  state_q  <= S_EDIV;
                end else begin
                  state_q <= S_MEAN;
                end
              end
              esc_pkg::ReqTick: begin
                if (mode_q) begin
                  state_q  <= S_TSCL;
                end else begin
                  state_q <= S_TERR;
                end
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_EDIV: if (div_st.done) begin
          state_q  <= S_EMUL;
        end
        S_EMUL: if (mul_st.done) begin
          if (req_b_q) begin
            speed_b_q <= spd_new;
          end else begin
            speed_a_q <= spd_new;
          end
          state_q <= S_MEAN;
        end
        S_MEAN: begin
          mean_q  <= 16'(({1'b0, speed_a_q} + {1'b0, speed_b_q}) >> 1);
          state_q <= S_DONE;
        end
        S_TSCL: if (mul_st.done) begin
          state_q  <= S_TDIV;
        end
        S_TDIV: if (div_st.done) begin
          state_q <= S_TERR;
        end
        S_TERR: begin
          setp_q   <= (xd_q > 16'd1023) ? 10'd1023 : xd_q[9:0];
          state_q  <= S_TFLT;
        end
        S_TFLT: if (mul_st.done) begin
          err_q    <= new_err;
          state_q  <= S_TGAIN;
        end
        S_TGAIN: if (mul_st.done) begin
          state_q  <= S_TOUT;
        end
        S_TOUT: if (mul_st.done) begin
          out_q   <= new_out;
          duty_q  <= new_duty;
          state_q <= S_DONE;
        end
        S_DONE: if (!m_valid_q || m_axis_tready) begin
          m_valid_q <= 1'b1;
          state_q   <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // operands and payload
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        req_b_q <= in_req[0];
        xd_q    <= {6'd0, in_pot};
        mul_a_q <= $signed({54'd0, in_pot});
        mul_b_q <= flim_q;
        div_n_q <= esc_pkg::ClockHz;
        div_d_q <= interval;
      end
      S_EDIV: begin
        mul_a_q <= freq_diff;
        mul_b_q <= {7'd0, slew_q};
      end
      S_TSCL: begin
        div_n_q <= mul_prod[esc_pkg::DivNW-1:0];
        div_d_q <= esc_pkg::SampleMax;
      end
      S_TDIV: xd_q <= div_quo[15:0];
      S_TERR: begin
        mul_a_q <= err_e;
        mul_b_q <= {7'd0, alpha_q};
      end
      S_TFLT: begin
        mul_a_q <= {{32{new_err[31]}}, new_err};
        mul_b_q <= gain_q;
      end
      S_TGAIN: begin
        mul_a_q <= inner;
        mul_b_q <= {7'd0, slew_q};
      end
      S_DONE: if (!m_valid_q || m_axis_tready) begin
        m_data_q <= {4'd0, setp_q, fe16, mean_q, duty_q};
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `ESC_ASSERT(a_accept_busy, clk_i, rst_ni, accept |=> state_q != S_IDLE, "request not taken up")
  `ESC_ASSERT_NEVER(a_mul_overrun, clk_i, rst_ni, mul_go_q && mul_st.busy, "multiplier restarted")
  `ESC_ASSERT_NEVER(a_div_overrun, clk_i, rst_ni, div_go_q && div_st.busy, "divider restarted")
  `ESC_ASSERT(a_result_src, clk_i, rst_ni, $rose(m_valid_q) |-> $past(state_q) == S_DONE, "stray result")

endmodule

// ===== rtl/core/esc_mul.sv =====
// Bit-serial shift-add multiplier: signed 64-bit multiplicand, unsigned 16-bit multiplier.
// Depends on esc_pkg.
module esc_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               go_i,
  input  logic signed [esc_pkg::MulW-1:0]    a_i,
  input  logic        [esc_pkg::MulBW-1:0]   b_i,
  output logic signed [esc_pkg::MulW-1:0]    prod_o,
  output esc_pkg::unit_st_t                  st_o
);

  logic                             busy_q, done_q;
  logic [esc_pkg::MulCntW-1:0]      cnt_q;
  logic signed [esc_pkg::MulW-1:0]  a_q, acc_q;
  logic [esc_pkg::MulBW-1:0]        b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= esc_pkg::MulCntW'(esc_pkg::MulBW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - esc_pkg::MulCntW'(1);
        if (cnt_q == esc_pkg::MulCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q <<< 1;
      b_q <= b_q >> 1;
    end
  end

  assign prod_o  = acc_q;
  assign st_o.busy = busy_q;
  assign st_o.done = done_q;

endmodule

// ===== rtl/core/esc_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on esc_pkg. Divisor must be non-zero.
module esc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          go_i,
  input  logic [esc_pkg::DivNW-1:0]     dividend_i,
  input  logic [esc_pkg::DivDW-1:0]     divisor_i,
  output logic [esc_pkg::DivNW-1:0]     quot_o,
  output esc_pkg::unit_st_t             st_o
);

  logic                          busy_q, done_q;
  logic [esc_pkg::DivCntW-1:0]   cnt_q;
  logic [esc_pkg::DivNW-1:0]     quo_q;
  logic [esc_pkg::DivDW-1:0]     rem_q, dvs_q;
  logic [esc_pkg::DivDW:0]       rem_sh;
  logic                          fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[esc_pkg::DivNW-1]};
    fits   = rem_sh >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= esc_pkg::DivCntW'(esc_pkg::DivNW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - esc_pkg::DivCntW'(1);
        if (cnt_q == esc_pkg::DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? esc_pkg::DivDW'(rem_sh - {1'b0, dvs_q}) : rem_sh[esc_pkg::DivDW-1:0];
      quo_q <= {quo_q[esc_pkg::DivNW-2:0], fits};
    end
  end

  assign quot_o    = quo_q;
  assign st_o.busy = busy_q;
  assign st_o.done = done_q;

endmodule

// ===== test/tb_encoder_speed_controller.sv =====
// Self-checking testbench for encoder_speed_controller: edge, tick and unused requests
// are checked against an in-bench predictor, with random idling on both streams.
// Depends on esc_pkg and the encoder_speed_controller RTL.
module tb_encoder_speed_controller;

  localparam logic [1:0] ReqUnused = 2'd3;
  localparam logic [esc_pkg::CfgIdxW-1:0] CfgNoneLo = 3'd5;
  localparam logic [esc_pkg::CfgIdxW-1:0] CfgNoneHi = 3'd7;

  typedef struct packed {
    logic [9:0]  setpoint;
    logic [15:0] ferr;
    logic [15:0] speed_avg;
    logic [9:0]  duty;
  } speed_result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  pot;
    logic [15:0] stamp;
  } speed_req_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [esc_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [esc_pkg::CfgW-1:0]    cfg_data_i = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [31:0]                 s_axis_tdata = '0;
  logic [1:0]                  s_axis_tuser = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [55:0]                 m_axis_tdata;

  encoder_speed_controller dut (.*);

  always #2 clk_i = ~clk_i;

  // predictor state
  longint gain_r, alpha_r, slew_r, mode_r, flim_r;
  longint last_t[2], phase_r[2], spd[2], mean_r, perr, pout, duty_r, setp_r;

  speed_req_t    req_q[$];
  speed_result_t result_q[$];
  speed_req_t    cur;
  bit            took;
  int            send_idle_pct, stall_pct;
  int            errors, n_req, n_res, n_ticks, n_edges;

  function automatic longint clip_s32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic speed_result_t step_speed(input speed_req_t r);
    speed_result_t res;
    longint itv, tgt, v, xd, e, num, fe;
    int ch;
    if (r.kind == esc_pkg::ReqEdgeA || r.kind == esc_pkg::ReqEdgeB) begin
      ch = (r.kind == esc_pkg::ReqEdgeB);
      itv = (longint'(r.stamp) - last_t[ch]) & 64'hFFFF;
      last_t[ch] = r.stamp;
      if (phase_r[ch] != 0) begin
        if (itv != 0) begin
          tgt = 32768 / itv;
          v = (spd[ch] * 256 + slew_r * (tgt - spd[ch])) / 256;
          spd[ch] = v < 0 ? 0 : (v > 65535 ? 65535 : v);
        end
        phase_r[ch] = 0;
      end else begin
        phase_r[ch] = 1;
      end
      mean_r = (spd[0] + spd[1]) / 2;
    end else if (r.kind == esc_pkg::ReqTick) begin
      xd = mode_r != 0 ? (longint'(r.pot) * flim_r) / 1023 : longint'(r.pot);
      setp_r = xd > 1023 ? 1023 : xd;
      e = xd - mean_r;
      num = alpha_r * e + (256 - alpha_r) * perr;
      perr = clip_s32(num / 256);
      num = pout * 65536 + slew_r * (xd * 256 + gain_r * perr - pout * 256);
      pout = clip_s32(num / 65536);
      duty_r = pout > 1023 ? 1023 : (pout < 0 ? 0 : pout);
    end
    fe = perr > 32767 ? 32767 : (perr < -32768 ? -32768 : perr);
    res.duty = duty_r[9:0];
    res.speed_avg = mean_r[15:0];
    res.ferr = fe[15:0];
    res.setpoint = setp_r[9:0];
    return res;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || took) begin
        took = 1'b0;
        if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur = req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= cur.kind;
          s_axis_tdata <= {6'd0, cur.pot, cur.stamp};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor and prediction
  always @(posedge clk_i) begin
    speed_result_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[51:0];
      n_res++;
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (got.duty !== want.duty)
          $display("%0t: duty exp %0d got %0d", $time, want.duty, got.duty);
        if (got.speed_avg !== want.speed_avg)
          $display("%0t: speed_avg exp %0d got %0d", $time, want.speed_avg, got.speed_avg);
        if (got.ferr !== want.ferr)
          $display("%0t: filtered_error exp %0d got %0d", $time,
                   $signed(want.ferr), $signed(got.ferr));
        if (got.setpoint !== want.setpoint)
          $display("%0t: setpoint exp %0d got %0d", $time, want.setpoint, got.setpoint);
        if (got !== want) errors++;
      end
    end
    if (s_axis_tvalid && s_axis_tready && !took) begin
      took = 1'b1;
      n_req++;
      if (cur.kind == esc_pkg::ReqTick) n_ticks++;
      if (cur.kind == esc_pkg::ReqEdgeA || cur.kind == esc_pkg::ReqEdgeB) n_edges++;
      result_q.push_back(step_speed(cur));
    end
  end

  task automatic write_reg(input logic [esc_pkg::CfgIdxW-1:0] idx, input longint val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[15:0];
    case (idx)
      esc_pkg::CfgGain:  gain_r = val & 64'hFFFF;
      esc_pkg::CfgAlpha: alpha_r = val & 64'h1FF;
      esc_pkg::CfgSlew:  slew_r = val & 64'h1FF;
      esc_pkg::CfgMode:  mode_r = val & 1;
      esc_pkg::CfgFlim:  flim_r = val & 64'hFFFF;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (req_q.size() > 0 || s_axis_tvalid || result_q.size() > 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic push_req(input logic [1:0] k, input logic [15:0] t, input logic [9:0] p);
    speed_req_t r;
    r.kind = k;
    r.stamp = t;
    r.pot = p;
    req_q.push_back(r);
  endtask

  // edges with random gaps and ticks with random content, plus some noise
  logic [15:0] clk_stamp[2];
  task automatic random_batch(input int count);
    int sel, ch;
    logic [15:0] gap;
    logic [9:0]  pot;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      ch = $urandom_range(1);
      if (sel < 55) begin
        case ($urandom_range(3))
          0: gap = 16'($urandom_range(8, 1));
          1: gap = 16'($urandom_range(300, 30));
          2: gap = 16'($urandom);
          default: gap = 16'($urandom_range(4000, 60));
        endcase
        if ($urandom_range(19) == 0) gap = '0;
        clk_stamp[ch] = clk_stamp[ch] + gap;
        push_req(ch ? esc_pkg::ReqEdgeB : esc_pkg::ReqEdgeA, clk_stamp[ch], 10'($urandom));
      end else if (sel < 92) begin
        if ($urandom_range(1)) pot = 10'($urandom_range(1023));
        else pot = $urandom_range(1) ? 10'd1023 : 10'd0;
        push_req(esc_pkg::ReqTick, 16'($urandom), pot);
      end else if (sel < 96) begin
        push_req(ReqUnused, 16'($urandom), 10'($urandom));
      end else begin
        clk_stamp[ch] = 16'($urandom);
        push_req(ch ? esc_pkg::ReqEdgeB : esc_pkg::ReqEdgeA, clk_stamp[ch], 10'($urandom));
      end
    end
  endtask

  int idle_tab[4][2] = '{'{0, 0}, '{51, 0}, '{0, 51}, '{13, 13}};

  initial begin
    gain_r = 128; alpha_r = 179; slew_r = 128; mode_r = 0; flim_r = 500;
    for (int c = 0; c < 2; c++) begin
      last_t[c] = 0; phase_r[c] = 0; spd[c] = 0; clk_stamp[c] = 0;
    end
    mean_r = 0; perr = 0; pout = 0; duty_r = 0; setp_r = 0;
    errors = 0; n_req = 0; n_res = 0; n_ticks = 0; n_edges = 0; took = 1'b0;
    send_idle_pct = 0; stall_pct = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, edge pairs, zero interval, wrap, extremes, unused type
    push_req(esc_pkg::ReqEdgeA, 16'd0, 10'd0);
    push_req(esc_pkg::ReqEdgeA, 16'd1, 10'd1023);
    push_req(esc_pkg::ReqEdgeB, 16'd100, 10'd0);
    push_req(esc_pkg::ReqEdgeB, 16'd100, 10'd0);
    push_req(esc_pkg::ReqEdgeB, 16'hFFFF, 10'd0);
    push_req(esc_pkg::ReqEdgeB, 16'd3, 10'd0);
    push_req(esc_pkg::ReqTick, 16'hFFFF, 10'd0);
    push_req(esc_pkg::ReqTick, 16'd0, 10'd1023);
    push_req(ReqUnused, 16'hFFFF, 10'd1023);
    push_req(esc_pkg::ReqEdgeA, 16'd10, 10'd0);
    push_req(esc_pkg::ReqEdgeA, 16'd9, 10'd0);
    push_req(esc_pkg::ReqTick, 16'hAAAA, 10'h155);
    push_req(esc_pkg::ReqTick, 16'h5555, 10'h2AA);
    wait_drained();

    // extremes of the registers, then mixed settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(esc_pkg::CfgGain, 0); write_reg(esc_pkg::CfgAlpha, 0);
          write_reg(esc_pkg::CfgSlew, 0);
          write_reg(esc_pkg::CfgMode, 0); write_reg(esc_pkg::CfgFlim, 1);
        end
        1: begin
          write_reg(esc_pkg::CfgGain, 65535); write_reg(esc_pkg::CfgAlpha, 256);
          write_reg(esc_pkg::CfgSlew, 256);
          write_reg(esc_pkg::CfgMode, 1); write_reg(esc_pkg::CfgFlim, 65535);
          push_req(esc_pkg::ReqTick, 16'd0, 10'd1023);
          push_req(esc_pkg::ReqTick, 16'd0, 10'd0);
        end
        2: begin
          write_reg(esc_pkg::CfgSlew, 511); write_reg(esc_pkg::CfgAlpha, 511);
          write_reg(esc_pkg::CfgGain, 1000);
          write_reg(CfgNoneLo, 16'hFFFF); write_reg(CfgNoneHi, 0);
        end
        3: begin
          write_reg(esc_pkg::CfgGain, 128); write_reg(esc_pkg::CfgAlpha, 179);
          write_reg(esc_pkg::CfgSlew, 128);
          write_reg(esc_pkg::CfgMode, 1); write_reg(esc_pkg::CfgFlim, 500);
        end
        default: begin
          write_reg(esc_pkg::CfgGain, $urandom_range(65535));
          write_reg(esc_pkg::CfgAlpha, $urandom_range(511));
          write_reg(esc_pkg::CfgSlew, $urandom_range(300));
          write_reg(esc_pkg::CfgMode, $urandom_range(1));
          write_reg(esc_pkg::CfgFlim, $urandom_range(65535, 1));
        end
      endcase
      for (int k = 0; k < 4; k++) begin
        send_idle_pct = idle_tab[(ph + k) % 4][0];
        stall_pct = idle_tab[(ph + k) % 4][1];
        random_batch(27);
        while (req_q.size() > 0) @(negedge clk_i);
      end
      wait_drained();
    end

    $display("covered %0d requests (%0d edges, %0d ticks), %0d results, register extremes",
             n_req, n_edges, n_ticks, n_res);
    if (errors == 0 && result_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end
endmodule
